### design/scs_pkg.sv
package scs_pkg;

   // Width of the sample counters (CountWidth) and of the result fields that carry them (SampleWidth)
   localparam int CountWidth  = 16;
   localparam int SampleWidth = 16;

   typedef enum logic [1:0] {
      ActDispatch = 2'd0,
      ActCheck    = 2'd1,
      ActRestart  = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      PhIdle    = 4'd0,
      PhProbe   = 4'd1,
      PhMove    = 4'd2,
      PhStroke  = 4'd3,
      PhLimit   = 4'd4,
      PhTravel  = 4'd5,
      PhZone    = 4'd6,
      PhLearn   = 4'd7,
      PhProfile = 4'd8,
      PhDone    = 4'd9,
      PhFail    = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      OcNone    = 3'd0,
      OcRun     = 3'd1,
      OcHoming  = 3'd2,
      OcFailed  = 3'd3,
      OcManual  = 3'd4,
      OcDone    = 3'd5
   } outcome_type;

   localparam logic [4:0] EvNone        = 5'd0;
   localparam logic [4:0] EvAbort       = 5'd1;
   localparam logic [4:0] EvFault       = 5'd2;
   localparam logic [4:0] EvStart       = 5'd3;
   localparam logic [4:0] EvLearnDone   = 5'd16;
   localparam logic [4:0] EvSampleOk    = 5'd17;
   localparam logic [4:0] EvSampleBad   = 5'd18;
   localparam logic [4:0] EvProfileDone = 5'd19;

   typedef struct packed {
      logic        accepted;
      phase_type   next_phase;
      outcome_type next_outcome;
   } decision_type;

   typedef struct packed {
      phase_type              phase;
      phase_type              phase_before;
      logic [4:0]             event_last;
      outcome_type            outcome;
      logic [CountWidth-1:0]  good_count;
      logic [CountWidth-1:0]  bad_count;
   } state_type;

   localparam state_type StateClear = '{
      phase:        PhIdle,
      phase_before: PhIdle,
      event_last:   EvNone,
      outcome:      OcNone,
      good_count:   '0,
      bad_count:    '0
   };

   // Outcome left behind by the fail event of the probe .. safe zone phases
   function automatic outcome_type fail_outcome(input phase_type phase);
      outcome_type oc;
      unique case (phase)
         PhMove, PhTravel: oc = OcManual;
         default:          oc = OcHoming;
      endcase
      return oc;
   endfunction

endpackage

### design/scs_decode.sv
module scs_decode (
   input  scs_pkg::phase_type    phase,
   input  scs_pkg::outcome_type  outcome,
   input  logic [4:0]            event_code,
   output scs_pkg::decision_type dec
);

   logic [4:0] pass_code;
   logic [4:0] fail_code;

   // Linear phases pair their pass and fail codes as 2*phase+2 and 2*phase+3
   assign pass_code = {phase, 1'b0} + 5'd2;
   assign fail_code = pass_code + 5'd1;

   always_comb begin
      dec.accepted     = 1'b0;
      dec.next_phase   = phase;
      dec.next_outcome = outcome;
      priority if (event_code == scs_pkg::EvAbort) begin
         dec.accepted     = 1'b1;
         dec.next_phase   = scs_pkg::PhFail;
         dec.next_outcome = scs_pkg::OcHoming;
      end else if (event_code == scs_pkg::EvFault) begin
         dec.accepted     = 1'b1;
         dec.next_phase   = scs_pkg::PhFail;
         dec.next_outcome = scs_pkg::OcFailed;
      end else begin
         unique case (phase)
            scs_pkg::PhIdle: begin
               if (event_code == scs_pkg::EvStart) begin
                  dec.accepted     = 1'b1;
                  dec.next_phase   = scs_pkg::PhProbe;
                  dec.next_outcome = scs_pkg::OcRun;
               end
            end
            scs_pkg::PhProbe, scs_pkg::PhMove, scs_pkg::PhStroke,
            scs_pkg::PhLimit, scs_pkg::PhTravel, scs_pkg::PhZone: begin
               if (event_code == pass_code) begin
                  dec.accepted   = 1'b1;
                  dec.next_phase = scs_pkg::phase_type'(phase + 4'd1);
               end else if (event_code == fail_code) begin
                  dec.accepted     = 1'b1;
                  dec.next_phase   = scs_pkg::PhFail;
                  dec.next_outcome = scs_pkg::fail_outcome(phase);
               end
            end
            scs_pkg::PhLearn: begin
               if (event_code == scs_pkg::EvLearnDone) begin
                  dec.accepted   = 1'b1;
                  dec.next_phase = scs_pkg::PhProfile;
               end else if (event_code == scs_pkg::EvSampleOk ||
                            event_code == scs_pkg::EvSampleBad) begin
                  dec.accepted = 1'b1;
               end
            end
            scs_pkg::PhProfile: begin
               if (event_code == scs_pkg::EvProfileDone) begin
                  dec.accepted     = 1'b1;
                  dec.next_phase   = scs_pkg::PhDone;
                  dec.next_outcome = scs_pkg::OcDone;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

### design/scs_state.sv
module scs_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  scs_pkg::action_type   action,
   input  logic [4:0]            event_code,
   input  scs_pkg::decision_type dec,
   output scs_pkg::state_type    state_ff,
   output scs_pkg::state_type    state_in
);

   localparam logic [scs_pkg::CountWidth-1:0] CountMax = '1;

   always_comb begin
      state_in = state_ff;
      unique case (action)
         scs_pkg::ActDispatch: begin
            if (dec.accepted) begin
               state_in.phase_before = state_ff.phase;
               state_in.phase        = dec.next_phase;
               state_in.event_last   = event_code;
               state_in.outcome      = dec.next_outcome;
               // samples only get through the decoder in the learning phase
               if (event_code == scs_pkg::EvSampleOk && state_ff.good_count != CountMax) begin
                  state_in.good_count = state_ff.good_count + 1'b1;
               end
               if (event_code == scs_pkg::EvSampleBad && state_ff.bad_count != CountMax) begin
                  state_in.bad_count = state_ff.bad_count + 1'b1;
               end
            end
         end
         scs_pkg::ActRestart: begin
            state_in = scs_pkg::StateClear;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scs_pkg::StateClear;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

### design/self_check_sequencer.sv
// Startup self-check sequencer for an actuator.
//
// Request channel (req_valid / req_stall): req_action selects dispatch, check
// only or restart; req_event_code carries the event. Every request yields
// exactly one response on rsp_valid / rsp_stall with the acceptance flag and
// a snapshot of the phase, previous phase, last event, outcome and the two
// sample counters after the request.
//
// A request waits in the input register until the response register is free,
// then rsp_valid rises. The block takes one request per cycle while the
// response register is free: a request is decoded from the input register
// against the live state, and the state registers and the response register
// are written on the same edge, so the next request already sees the update.
//
// When the receiver stalls, the response register holds; one more request
// waits in the input register, and after that req_stall goes high until the
// response is taken.
//
// Synchronous reset clears the phase to idle, the history fields and the
// counters to zero, and empties both pipeline registers.
module self_check_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_event_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [3:0]  rsp_phase_out,
   output logic [3:0]  rsp_previous_phase_out,
   output logic [4:0]  rsp_last_event_out,
   output logic [2:0]  rsp_outcome_out,
   output logic [15:0] rsp_good_samples,
   output logic [15:0] rsp_bad_samples
);

   logic                  in_valid_ff;
   scs_pkg::action_type   in_action_ff;
   logic [4:0]            in_event_ff;
   logic                  out_free;
   logic                  step;
   logic                  ok;
   scs_pkg::decision_type dec;
   scs_pkg::state_type    state_ff;
   scs_pkg::state_type    state_in;
   logic                  rsp_valid_ff;
   logic                  rsp_accepted_ff;
   scs_pkg::state_type    rsp_state_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   scs_decode u_decode (
      .phase      (state_ff.phase),
      .outcome    (state_ff.outcome),
      .event_code (in_event_ff),
      .dec        (dec)
   );

   scs_state u_state (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .action     (in_action_ff),
      .event_code (in_event_ff),
      .dec        (dec),
      .state_ff   (state_ff),
      .state_in   (state_in)
   );

   assign ok = (in_action_ff == scs_pkg::ActDispatch || in_action_ff == scs_pkg::ActCheck)
               && dec.accepted;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff <= scs_pkg::action_type'(req_action);
         in_event_ff  <= req_event_code;
      end
      if (step) begin
         rsp_accepted_ff <= ok;
         rsp_state_ff    <= state_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_accepted           = rsp_accepted_ff;
   assign rsp_phase_out          = rsp_state_ff.phase;
   assign rsp_previous_phase_out = rsp_state_ff.phase_before;
   assign rsp_last_event_out     = rsp_state_ff.event_last;
   assign rsp_outcome_out        = rsp_state_ff.outcome;

   generate
      if (scs_pkg::CountWidth >= scs_pkg::SampleWidth) begin : g_cnt_trunc
         assign rsp_good_samples = rsp_state_ff.good_count[scs_pkg::SampleWidth-1:0];
         assign rsp_bad_samples  = rsp_state_ff.bad_count[scs_pkg::SampleWidth-1:0];
      end else begin : g_cnt_ext
         assign rsp_good_samples = {{(scs_pkg::SampleWidth - scs_pkg::CountWidth){1'b0}},
                                    rsp_state_ff.good_count};
         assign rsp_bad_samples  = {{(scs_pkg::SampleWidth - scs_pkg::CountWidth){1'b0}},
                                    rsp_state_ff.bad_count};
      end
   endgenerate

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (step && in_action_ff == scs_pkg::ActRestart) |=>
         (state_ff == scs_pkg::StateClear))
      else $error("restart left state behind");

   a_good_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(step && in_action_ff == scs_pkg::ActRestart) |=>
         (state_ff.good_count >= $past(state_ff.good_count)))
      else $error("good sample count went down");

   a_last_event: assert property (@(posedge clock) disable iff (reset)
      (step && in_action_ff == scs_pkg::ActDispatch && dec.accepted) |=>
         (state_ff.event_last == $past(in_event_ff) &&
          state_ff.phase_before == $past(state_ff.phase)))
      else $error("accepted dispatch not recorded");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(state_ff))
      else $error("state changed without a request");

endmodule

### test/phase_tracker_check.sv
`timescale 1ns / 100ps

module phase_tracker_check import scs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_event_code,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_accepted,
   input  logic [3:0]  rsp_phase_out,
   input  logic [3:0]  rsp_previous_phase_out,
   input  logic [4:0]  rsp_last_event_out,
   input  logic [2:0]  rsp_outcome_out,
   input  logic [15:0] rsp_good_samples,
   input  logic [15:0] rsp_bad_samples,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic                   accepted;
      logic [3:0]             phase;
      logic [3:0]             prior;
      logic [4:0]             last_ev;
      logic [2:0]             outcome;
      logic [SampleWidth-1:0] good;
      logic [SampleWidth-1:0] bad;
   } snapshot_type;

   phase_type              cur_phase;
   phase_type              prior_phase;
   logic [4:0]             last_ev;
   outcome_type            cur_outcome;
   logic [CountWidth-1:0]  good_cnt;
   logic [CountWidth-1:0]  bad_cnt;
   snapshot_type           snapshot_q[$];

   function automatic void clear_tracker();
      cur_phase   = PhIdle;
      prior_phase = PhIdle;
      last_ev     = EvNone;
      cur_outcome = OcNone;
      good_cnt    = '0;
      bad_cnt     = '0;
   endfunction

   function automatic decision_type judge_event(phase_type ph, outcome_type oc,
                                                logic [4:0] ev);
      decision_type d;
      logic [4:0]   pass_ev;
      outcome_type  fail_oc;
      d       = '{accepted: 1'b0, next_phase: ph, next_outcome: oc};
      pass_ev = 5'(2 * ph + 2);
      fail_oc = (ph == PhMove || ph == PhTravel) ? OcManual : OcHoming;
      if (ev == EvAbort) begin
         d = '{accepted: 1'b1, next_phase: PhFail, next_outcome: OcHoming};
      end else if (ev == EvFault) begin
         d = '{accepted: 1'b1, next_phase: PhFail, next_outcome: OcFailed};
      end else begin
         case (ph)
            PhIdle: begin
               if (ev == EvStart)
                  d = '{accepted: 1'b1, next_phase: PhProbe, next_outcome: OcRun};
            end
            PhProbe, PhMove, PhStroke, PhLimit, PhTravel, PhZone: begin
               if (ev == pass_ev)
                  d = '{accepted: 1'b1, next_phase: phase_type'(ph + 1), next_outcome: oc};
               else if (ev == pass_ev + 5'd1)
                  d = '{accepted: 1'b1, next_phase: PhFail, next_outcome: fail_oc};
            end
            PhLearn: begin
               if (ev == EvLearnDone)
                  d = '{accepted: 1'b1, next_phase: PhProfile, next_outcome: oc};
               else if (ev == EvSampleOk || ev == EvSampleBad)
                  d.accepted = 1'b1;
            end
            PhProfile: begin
               if (ev == EvProfileDone)
                  d = '{accepted: 1'b1, next_phase: PhDone, next_outcome: OcDone};
            end
            default: ;
         endcase
      end
      return d;
   endfunction

   // Applies one request to the tracked state and returns the response it implies
   function automatic snapshot_type advance_tracker(logic [1:0] act, logic [4:0] ev);
      decision_type d;
      snapshot_type s;
      d          = judge_event(cur_phase, cur_outcome, ev);
      s.accepted = 1'b0;
      case (act)
         ActDispatch: begin
            s.accepted = d.accepted;
            if (d.accepted) begin
               prior_phase = cur_phase;
               cur_phase   = d.next_phase;
               last_ev     = ev;
               cur_outcome = d.next_outcome;
               if (ev == EvSampleOk && good_cnt != '1)
                  good_cnt = good_cnt + 1'b1;
               else if (ev == EvSampleBad && bad_cnt != '1)
                  bad_cnt = bad_cnt + 1'b1;
            end
         end
         ActCheck:   s.accepted = d.accepted;
         ActRestart: clear_tracker();
         default: ;
      endcase
      s.phase   = cur_phase;
      s.prior   = prior_phase;
      s.last_ev = last_ev;
      s.outcome = cur_outcome;
      s.good    = good_cnt[SampleWidth-1:0];
      s.bad     = bad_cnt[SampleWidth-1:0];
      return s;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < 40)
         $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      snapshot_type want;
      if (reset) begin
         clear_tracker();
         snapshot_q.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (snapshot_q.size() == 0) begin
               report("response with no request pending", rsp_phase_out, 0);
            end else begin
               want = snapshot_q.pop_front();
               if (rsp_accepted !== want.accepted)
                  report("accepted", rsp_accepted, want.accepted);
               if (rsp_phase_out !== want.phase)
                  report("phase", rsp_phase_out, want.phase);
               if (rsp_previous_phase_out !== want.prior)
                  report("previous phase", rsp_previous_phase_out, want.prior);
               if (rsp_last_event_out !== want.last_ev)
                  report("last event", rsp_last_event_out, want.last_ev);
               if (rsp_outcome_out !== want.outcome)
                  report("outcome", rsp_outcome_out, want.outcome);
               if (rsp_good_samples !== want.good)
                  report("good samples", rsp_good_samples, want.good);
               if (rsp_bad_samples !== want.bad)
                  report("bad samples", rsp_bad_samples, want.bad);
            end
         end
         if (req_valid && !req_stall)
            snapshot_q.push_back(advance_tracker(req_action, req_event_code));
      end
      outstanding = snapshot_q.size();
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import scs_pkg::*;

   localparam logic [1:0] ActUnused     = 2'd3;
   localparam logic [4:0] EvFirstUnused = 5'd20;
   localparam logic [4:0] EvLastCode    = 5'd31;
   localparam int RandomItems   = 1850;
   localparam int DrainEvery    = 400;
   localparam int BurstSteps    = 16;
   localparam int CycleLimit    = 2_000_000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic [1:0]  req_action     = ActDispatch;
   logic [4:0]  req_event_code = EvNone;
   logic        rsp_stall      = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_accepted;
   logic [3:0]  rsp_phase_out;
   logic [3:0]  rsp_previous_phase_out;
   logic [4:0]  rsp_last_event_out;
   logic [2:0]  rsp_outcome_out;
   logic [15:0] rsp_good_samples;
   logic [15:0] rsp_bad_samples;

   int mismatches;
   int outstanding;
   int sent_items  = 0;
   int quiet_left  = 0;
   int stall_left  = 0;
   int next_drain;
   bit gaps_on     = 1'b1;
   bit stalls_on   = 1'b1;

   self_check_sequencer dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_action             (req_action),
      .req_event_code         (req_event_code),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_accepted           (rsp_accepted),
      .rsp_phase_out          (rsp_phase_out),
      .rsp_previous_phase_out (rsp_previous_phase_out),
      .rsp_last_event_out     (rsp_last_event_out),
      .rsp_outcome_out        (rsp_outcome_out),
      .rsp_good_samples       (rsp_good_samples),
      .rsp_bad_samples        (rsp_bad_samples)
   );

   phase_tracker_check tracker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_action             (req_action),
      .req_event_code         (req_event_code),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_accepted           (rsp_accepted),
      .rsp_phase_out          (rsp_phase_out),
      .rsp_previous_phase_out (rsp_previous_phase_out),
      .rsp_last_event_out     (rsp_last_event_out),
      .rsp_outcome_out        (rsp_outcome_out),
      .rsp_good_samples       (rsp_good_samples),
      .rsp_bad_samples        (rsp_bad_samples),
      .mismatches             (mismatches),
      .outstanding            (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure: short bursts mostly, occasional long stalls and long free runs
   always @(negedge clock) begin
      int r;
      if (!stalls_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(0, 4);
         end else if (r < 88) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else if (r < 95) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(5, 25);
         end else begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(20, 80);
         end
      end
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) quiet_left = $urandom_range(20, 60);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [4:0] pass_code(phase_type ph);
      return 5'(2 * ph + 2);
   endfunction

   task automatic pause_request(int cycles);
      @(negedge clock);
      req_valid      <= 1'b0;
      req_action     <= 2'($urandom);
      req_event_code <= 5'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send(logic [1:0] act, logic [4:0] ev);
      int gap;
      gap = pick_gap();
      if (gap > 0) pause_request(gap);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_event_code <= ev;
      do @(posedge clock); while (req_stall !== 1'b0);
      sent_items++;
   endtask

   task automatic drain_responses();
      pause_request(1);
      while (outstanding != 0) @(negedge clock);
   endtask

   // Requests that never move the phase: check only, unused action, none or unlisted code
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0:       send(ActCheck, 5'($urandom));
         1:       send(ActUnused, 5'($urandom));
         2:       send(ActDispatch, EvNone);
         default: send(ActDispatch, 5'($urandom_range(EvFirstUnused, EvLastCode)));
      endcase
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 4) == 0) send_noise();
   endtask

   // One startup walk from a cleared state, with random early exits
   task automatic run_startup();
      logic [4:0] pass_ev;
      send(ActRestart, 5'($urandom));
      maybe_noise();
      send(ActDispatch, EvStart);
      for (int p = PhProbe; p <= PhZone; p++) begin
         pass_ev = pass_code(phase_type'(p));
         maybe_noise();
         if ($urandom_range(0, 13) == 0) begin
            send(ActDispatch, pass_ev + 5'd1);
            return;
         end
         if ($urandom_range(0, 29) == 0) begin
            send(ActDispatch, $urandom_range(0, 1) ? EvAbort : EvFault);
            return;
         end
         if ($urandom_range(0, 5) == 0) send(ActCheck, pass_ev);
         send(ActDispatch, pass_ev);
      end
      repeat ($urandom_range(0, 12)) begin
         maybe_noise();
         send(ActDispatch, $urandom_range(0, 1) ? EvSampleOk : EvSampleBad);
      end
      if ($urandom_range(0, 9) == 0) begin
         send(ActDispatch, $urandom_range(0, 1) ? EvAbort : EvFault);
         return;
      end
      send(ActDispatch, EvLearnDone);
      maybe_noise();
      send(ActDispatch, EvProfileDone);
      repeat ($urandom_range(0, 2))
         send($urandom_range(0, 1) ? ActDispatch : ActCheck, 5'($urandom));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(ActRestart, EvNone);
      send(ActCheck, EvStart);
      send(ActDispatch, EvNone);
      send(ActDispatch, EvLastCode);
      send(ActUnused, EvStart);
      send(ActDispatch, EvProfileDone);
      send(ActDispatch, EvStart);
      send(ActCheck, pass_code(PhProbe) + 5'd1);
      for (int p = PhProbe; p <= PhZone; p++)
         send(ActDispatch, pass_code(phase_type'(p)));
      send(ActDispatch, EvSampleOk);
      send(ActDispatch, EvSampleBad);
      send(ActDispatch, EvLearnDone);
      send(ActDispatch, EvProfileDone);
      send(ActDispatch, EvStart);
      send(ActDispatch, EvAbort);
      send(ActDispatch, EvFault);
      send(ActRestart, EvFault);
      send(ActDispatch, EvStart);
      send(ActDispatch, pass_code(PhProbe) + 5'd1);
      send(ActRestart, EvFirstUnused);

      next_drain = sent_items + DrainEvery;
      while (sent_items < RandomItems) begin
         if ($urandom_range(0, 3) != 0) begin
            run_startup();
         end else begin
            repeat ($urandom_range(1, 6)) send(2'($urandom), 5'($urandom));
         end
         if (sent_items >= next_drain) begin
            drain_responses();
            next_drain = sent_items + DrainEvery;
         end
      end

      // Back-to-back sample requests with no gaps and no receiver stalls
      drain_responses();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send(ActRestart, EvNone);
      send(ActDispatch, EvStart);
      for (int p = PhProbe; p <= PhZone; p++)
         send(ActDispatch, pass_code(phase_type'(p)));
      for (int i = 0; i < BurstSteps; i++) begin
         send(ActDispatch, EvSampleOk);
         send(ActDispatch, EvSampleBad);
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send(ActCheck, EvSampleOk);
      send(ActDispatch, EvLearnDone);
      send(ActDispatch, EvProfileDone);
      send(ActRestart, EvNone);
      send(ActDispatch, EvStart);

      pause_request(1);
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### sim.f
design/scs_pkg.sv
design/scs_decode.sv
design/scs_state.sv
design/self_check_sequencer.sv
test/phase_tracker_check.sv
test/tb_top.sv
